### sv/csec_pkg.sv
// Shared types and constants for the color sort eject controller.
`timescale 1ns / 1ps
`default_nettype none
package csec_pkg;

  localparam int unsigned HUE_W   = 12;
  localparam int unsigned PROX_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Hue thresholds in tenths of a degree
  localparam logic [HUE_W-1:0] RED_LOW_TENTHS   = 12'd250;
  localparam logic [HUE_W-1:0] RED_HIGH_TENTHS  = 12'd3300;
  localparam logic [HUE_W-1:0] BLUE_LOW_TENTHS  = 12'd2100;
  localparam logic [HUE_W-1:0] BLUE_HIGH_TENTHS = 12'd2400;

  // Register reset values
  localparam logic [SPEED_W-1:0] MANUAL_SPEED_RST    = 8'd0;
  localparam logic               SORT_ENABLE_RST     = 1'b0;
  localparam logic               OWN_COLOR_RED_RST   = 1'b1;
  localparam logic [PROX_W-1:0]  PROXIMITY_LIMIT_RST = 8'd225;
  localparam logic [MS_W-1:0]    EJECT_DELAY_RST     = 16'd150;
  localparam logic [MS_W-1:0]    EJECT_HOLD_RST      = 16'd350;
  localparam logic [SPEED_W-1:0] EJECT_SPEED_RST     = 8'd127;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MANUAL_SPEED    = 3'd0,
    REG_SORT_ENABLE     = 3'd1,
    REG_OWN_COLOR_RED   = 3'd2,
    REG_PROXIMITY_LIMIT = 3'd3,
    REG_EJECT_DELAY     = 3'd4,
    REG_EJECT_HOLD      = 3'd5,
    REG_EJECT_SPEED     = 3'd6
  } cfg_reg_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_EJECT = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] manual_speed;
    logic                      sort_enable;
    logic                      own_color_red;
    logic [PROX_W-1:0]         proximity_limit;
    logic [MS_W-1:0]           eject_delay_ms;
    logic [MS_W-1:0]           eject_hold_ms;
    logic signed [SPEED_W-1:0] eject_speed;
  } cfg_t;

  typedef struct packed {
    logic                      valid;
    logic signed [SPEED_W-1:0] motor_cmd;
    logic [PHASE_W-1:0]        phase_out;
  } result_t;

endpackage
`default_nettype wire

### sv/csec_if.sv
// Handshake channel interfaces for samples, results and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface csec_sample_if;
  logic                            valid;
  logic                            ready;
  logic [csec_pkg::HUE_W-1:0]      hue_tenths;
  logic [csec_pkg::PROX_W-1:0]     proximity_level;
  logic [csec_pkg::TIME_W-1:0]     now_ms;
  modport source (output valid, hue_tenths, proximity_level, now_ms, input ready);
  modport sink (input valid, hue_tenths, proximity_level, now_ms, output ready);
endinterface

interface csec_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [csec_pkg::SPEED_W-1:0] motor_cmd;
  logic [csec_pkg::PHASE_W-1:0]       phase_out;
  modport source (output valid, motor_cmd, phase_out, input ready);
  modport sink (input valid, motor_cmd, phase_out, output ready);
endinterface

interface csec_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [csec_pkg::CFG_ADDR_W-1:0]  addr;
  logic [csec_pkg::CFG_DATA_W-1:0]  wdata;
  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

### sv/csec_cfg_regs.sv
// Configuration register bank.
`timescale 1ns / 1ps
`default_nettype none
module csec_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  csec_cfg_if.sink           cfg,
  output csec_pkg::cfg_t     regs
);
  import csec_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.manual_speed    <= MANUAL_SPEED_RST;
      regs.sort_enable     <= SORT_ENABLE_RST;
      regs.own_color_red   <= OWN_COLOR_RED_RST;
      regs.proximity_limit <= PROXIMITY_LIMIT_RST;
      regs.eject_delay_ms  <= EJECT_DELAY_RST;
      regs.eject_hold_ms   <= EJECT_HOLD_RST;
      regs.eject_speed     <= EJECT_SPEED_RST;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_MANUAL_SPEED:    regs.manual_speed    <= cfg.wdata[SPEED_W-1:0];
        REG_SORT_ENABLE:     regs.sort_enable     <= cfg.wdata[0];
        REG_OWN_COLOR_RED:   regs.own_color_red   <= cfg.wdata[0];
        REG_PROXIMITY_LIMIT: regs.proximity_limit <= cfg.wdata[PROX_W-1:0];
        REG_EJECT_DELAY:     regs.eject_delay_ms  <= cfg.wdata[MS_W-1:0];
        REG_EJECT_HOLD:      regs.eject_hold_ms   <= cfg.wdata[MS_W-1:0];
        REG_EJECT_SPEED:     regs.eject_speed     <= cfg.wdata[SPEED_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/csec_core.sv
// Sample register, phase and deadline state, and the per-sample decision logic.
`timescale 1ns / 1ps
`default_nettype none
module csec_core (
  input  wire logic          clk,
  input  wire logic          rst,
  csec_sample_if.sink        sample,
  input  wire csec_pkg::cfg_t regs,
  input  wire logic          res_room,
  output csec_pkg::result_t  res
);
  import csec_pkg::*;

  logic              s1_valid;
  logic [HUE_W-1:0]  s1_hue;
  logic [PROX_W-1:0] s1_prox;
  logic [TIME_W-1:0] s1_now;
  logic              s1_go;

  phase_t            phase, phase_next;
  logic [TIME_W-1:0] deadline, deadline_next;

  logic is_red, is_blue, is_close, hit, expired;

  assign s1_go        = s1_valid && res_room;
  assign sample.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
    if (sample.ready && sample.valid) begin
      s1_hue  <= sample.hue_tenths;
      s1_prox <= sample.proximity_level;
      s1_now  <= sample.now_ms;
    end
  end

  assign is_red   = (s1_hue < RED_LOW_TENTHS) || (s1_hue > RED_HIGH_TENTHS);
  assign is_blue  = (s1_hue > BLUE_LOW_TENTHS) && (s1_hue < BLUE_HIGH_TENTHS);
  assign is_close = s1_prox > regs.proximity_limit;
  assign hit      = regs.own_color_red ? is_blue : is_red;
  assign expired  = s1_now > deadline;

  always_comb begin
    phase_next    = phase;
    deadline_next = deadline;
    res.valid     = s1_go;
    res.motor_cmd = regs.manual_speed;
    unique case (phase)
      PH_EJECT: begin
        res.motor_cmd = regs.eject_speed;
        if (expired) phase_next = PH_IDLE;
      end
      PH_ARMED: begin
        if (expired) begin
          // start ejecting; this sample yields no command
          phase_next    = PH_EJECT;
          deadline_next = s1_now + TIME_W'(regs.eject_hold_ms);
          res.valid     = 1'b0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (regs.sort_enable && is_close && hit) begin
          phase_next    = PH_ARMED;
          deadline_next = s1_now + TIME_W'(regs.eject_delay_ms);
        end
      end
    endcase
    res.phase_out = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      deadline <= '0;
    end else if (s1_go) begin
      phase    <= phase_next;
      deadline <= deadline_next;
    end
  end
endmodule
`default_nettype wire

### sv/csec_out_queue.sv
// Two-entry result queue that decouples the core from a stalled consumer.
`timescale 1ns / 1ps
`default_nettype none
module csec_out_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire csec_pkg::result_t res,
  output logic               room,
  csec_result_if.source      result
);
  import csec_pkg::*;

  typedef struct packed {
    logic signed [SPEED_W-1:0] motor_cmd;
    logic [PHASE_W-1:0]        phase_out;
  } entry_t;

  entry_t     mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign room          = count != 2'd2;
  assign push          = res.valid;
  assign pop           = result.valid && result.ready;
  assign result.valid  = count != 2'd0;
  assign result.motor_cmd = mem[rd_ptr].motor_cmd;
  assign result.phase_out = mem[rd_ptr].phase_out;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{motor_cmd: res.motor_cmd, phase_out: res.phase_out};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/color_sort_eject_controller.sv
// Top level of the color sort eject controller.
`timescale 1ns / 1ps
`default_nettype none
// Takes one sensor sample (hue in tenths of a degree, proximity, millisecond
// time) per transfer and returns at most one motor command with the phase
// after that sample. Throughput is one sample per clock: the whole decision
// (two hue window compares, one proximity compare, one 32-bit deadline
// compare and two 32-bit adds) sits between the sample register and a
// two-entry result queue, so a stalled consumer does not stop sampling until
// the queue fills. A sample passes the sample register and then a result
// queue entry before its result is offered to the consumer. A sample that
// ends the arming delay yields no result and itself starts the eject hold.
// Deadlines wrap modulo 2^32 and use unsigned compares, so a deadline that
// wraps expires at once. Write the configuration registers only while no
// sample is in flight; the write port is always ready and ignores indexes
// past the register list.
module color_sort_eject_controller (
  input  wire logic      clk,
  input  wire logic      rst,
  csec_sample_if.sink    sample,
  csec_result_if.source  result,
  csec_cfg_if.sink       cfg
);
  import csec_pkg::*;

  cfg_t    regs;
  result_t res;
  logic    res_room;

  // register bank
  csec_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // sample register, phase state and decision
  csec_core u_core (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .regs     (regs),
    .res_room (res_room),
    .res      (res)
  );

  // hold results until the consumer takes them
  csec_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .res    (res),
    .room   (res_room),
    .result (result)
  );

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res_room)
    else $error("result pushed into a full queue");

  // An ejecting result always carries the eject speed.
  a_eject_cmd: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.phase_out == PH_EJECT) |-> res.motor_cmd == regs.eject_speed)
    else $error("eject phase without eject speed");

  // A pending result leaves only through a transfer.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> result.valid)
    else $error("pending result dropped");

endmodule
`default_nettype wire
